// File: hw/rtl/sssp_pkg.sv
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared types and constants of the shortest path engine.
// ----------------------------------------------------------------------------
package sssp_pkg;

    localparam int NODES       = 32;
    localparam int WEIGHT_BITS = 16;
    localparam int VB          = $clog2(NODES);
    localparam int CB          = $clog2(NODES + 1);
    localparam int DIST_BITS   = 21;
    localparam int DW          = WEIGHT_BITS + CB;
    localparam int ADDR_BITS   = 2 * VB;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_UNREACH = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CLEAR  = 10'b0000000010,
        S_INIT   = 10'b0000000100,
        S_RELAX  = 10'b0000001000,
        S_SEARCH = 10'b0000010000,
        S_TRACE  = 10'b0000100000,
        S_EMIT   = 10'b0001000000,
        S_TRD    = 10'b0010000000,
        S_EMITW  = 10'b0100000000,
        S_ONE    = 10'b1000000000
    } state_t;

endpackage

// File: hw/rtl/single_source_shortest_path.sv
// A query runs a relax pass over the columns and a minimum scan per settled
// vertex, then a trace step and an emit step per path vertex; emitting waits
// while m_tready stalls.
// One item is handled at a time; no new item is accepted until back in idle.
// Reset: asynchronous; after reset a clearing pass sweeps the matrix memory
// while no item is accepted.
// ----------------------------------------------------------------------------
// single_source_shortest_path
// Dijkstra engine over an adjacency matrix held in one synchronous memory.
// ----------------------------------------------------------------------------
module single_source_shortest_path
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // func[1:0], vertex_a[6:2], vertex_b[11:7], weight[27:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[1:0], distance[22:2], path_vertex[27:23]
    output logic        m_tlast    // last
);

    localparam int N = sssp_pkg::NODES;
    localparam int VB = sssp_pkg::VB;
    localparam int CB = sssp_pkg::CB;
    localparam int DW = sssp_pkg::DW;
    localparam int AB = sssp_pkg::ADDR_BITS;
    localparam int WB = sssp_pkg::WEIGHT_BITS;

    logic [WB-1:0] mem [0:N*N-1];
    logic [WB-1:0] rd_data;
    logic          mem_we;
    logic [AB-1:0] mem_wa, mem_ra;
    logic [WB-1:0] mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[mem_ra];
    end

    logic [DW-1:0] dist_reg [0:N-1];
    logic [N-1:0]  settled_reg, haspred_reg, present_reg, present_next;
    logic [VB-1:0] pred_reg [0:N-1];
    logic [VB-1:0] stack_reg [0:N-1];

    sssp_pkg::state_t state_reg, state_next;
    logic [AB:0]   cnt_reg, cnt_next;
    logic [VB-1:0] src_reg, dst_reg, u_reg, u_next;
    logic [CB-1:0] depth_reg, depth_next;
    logic          rd_vld_reg;
    logic [VB-1:0] rd_col_reg;
    logic          found_reg, found_next;
    logic [DW-1:0] best_reg, best_next;
    logic [VB-1:0] bidx_reg, bidx_next;
    logic [1:0]    ost_reg;
    logic [sssp_pkg::DIST_BITS-1:0] odist_reg;
    logic [VB-1:0] ovtx_reg;
    logic          olast_reg, ovld_reg;

    logic [1:0]    in_func;
    logic [VB-1:0] in_a, in_b;
    logic [WB-1:0] in_w;
    logic          in_acc, out_free;
    assign in_func  = s_tdata[1:0];
    assign in_a     = s_tdata[2 +: VB];
    assign in_b     = s_tdata[7 +: VB];
    assign in_w     = s_tdata[12 +: WB];
    assign s_tready = (state_reg == sssp_pkg::S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !ovld_reg || m_tready;

    assign m_tvalid = ovld_reg;
    assign m_tdata  = {4'd0, ovtx_reg, odist_reg, ost_reg};
    assign m_tlast  = olast_reg;

    // relaxation candidate for the column read last cycle
    logic [DW-1:0] cand;
    assign cand = dist_reg[u_reg] + DW'(rd_data);

    logic [VB-1:0] cnt_v;
    assign cnt_v = cnt_reg[VB-1:0];

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        u_next       = u_reg;
        depth_next   = depth_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        bidx_next    = bidx_reg;
        present_next = present_reg;
        mem_we       = 1'b0;
        mem_wa       = cnt_reg[AB-1:0];
        mem_wd       = '0;
        mem_ra       = {u_reg, cnt_v};
        case (state_reg)
            sssp_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_func)
                        sssp_pkg::FUNC_WRITE:
                        begin
                            mem_we = 1'b1;
                            mem_wa = {in_a, in_b};
                            mem_wd = in_w;
                            present_next[in_a] = 1'b1;
                            present_next[in_b] = 1'b1;
                        end
                        sssp_pkg::FUNC_CLEAR:
                        begin
                            present_next = '0;
                            cnt_next     = '0;
                            state_next   = sssp_pkg::S_CLEAR;
                        end
                        sssp_pkg::FUNC_QUERY:
                        begin
                            if (!present_reg[in_a] || !present_reg[in_b])
                                state_next = sssp_pkg::S_ONE;
                            else
                                state_next = sssp_pkg::S_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            sssp_pkg::S_CLEAR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AB+1)'(N*N-1))
                    state_next = sssp_pkg::S_IDLE;
            end
            sssp_pkg::S_INIT:
            begin
                u_next     = src_reg;
                cnt_next   = '0;
                state_next = sssp_pkg::S_RELAX;
            end
            sssp_pkg::S_RELAX:
            begin
                // issue reads for columns 0..N-1, then a final step at count N drains
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AB+1)'(N))
                begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = sssp_pkg::S_SEARCH;
                end
            end
            sssp_pkg::S_SEARCH:
            begin
                if (cnt_reg == (AB+1)'(N))
                begin
                    cnt_next = '0;
                    if (found_reg)
                    begin
                        u_next     = bidx_reg;
                        state_next = sssp_pkg::S_RELAX;
                    end
                    else if (dst_reg != src_reg && !haspred_reg[dst_reg])
                        state_next = sssp_pkg::S_ONE;
                    else
                    begin
                        u_next     = dst_reg;
                        depth_next = '0;
                        state_next = sssp_pkg::S_TRACE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (!settled_reg[cnt_v] && haspred_reg[cnt_v]
                        && (!found_reg || dist_reg[cnt_v] < best_reg))
                    begin
                        found_next = 1'b1;
                        best_next  = dist_reg[cnt_v];
                        bidx_next  = cnt_v;
                    end
                end
            end
            sssp_pkg::S_TRACE:
            begin
                depth_next = depth_reg + 1'b1;
                if (u_reg == src_reg || !haspred_reg[u_reg]
                    || depth_reg == CB'(N-1))
                    state_next = sssp_pkg::S_EMIT;
                else
                    u_next = pred_reg[u_reg];
            end
            sssp_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    depth_next = depth_reg - 1'b1;
                    if (depth_reg == CB'(1))
                        state_next = sssp_pkg::S_IDLE;
                end
            end
            sssp_pkg::S_ONE:
            begin
                if (out_free)
                    state_next = sssp_pkg::S_IDLE;
            end
            default: state_next = sssp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sssp_pkg::S_CLEAR;
            cnt_reg     <= '0;
            present_reg <= '0;
            ovld_reg    <= 1'b0;
            rd_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            present_reg <= present_next;
            found_reg   <= found_next;
            rd_vld_reg  <= (state_reg == sssp_pkg::S_RELAX) && (cnt_reg < (AB+1)'(N));
            ovld_reg    <= ((state_reg == sssp_pkg::S_EMIT || state_reg == sssp_pkg::S_ONE)
                            && out_free) || (ovld_reg && !m_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        depth_reg  <= depth_next;
        best_reg   <= best_next;
        bidx_reg   <= bidx_next;
        rd_col_reg <= cnt_v;
        if (in_acc)
        begin
            src_reg <= in_a;
            dst_reg <= in_b;
        end
        if (state_reg == sssp_pkg::S_INIT)
        begin
            settled_reg <= ~present_reg | (N'(1) << src_reg);
            haspred_reg <= '0;
            for (int i = 0; i < N; i++)
                dist_reg[i] <= '0;
        end
        if (state_reg == sssp_pkg::S_SEARCH && cnt_reg == (AB+1)'(N) && found_reg)
            settled_reg[bidx_reg] <= 1'b1;
        if (rd_vld_reg && !settled_reg[rd_col_reg] && rd_data != '0
            && (!haspred_reg[rd_col_reg] || cand < dist_reg[rd_col_reg]))
        begin
            dist_reg[rd_col_reg]    <= cand;
            pred_reg[rd_col_reg]    <= u_reg;
            haspred_reg[rd_col_reg] <= 1'b1;
        end
        if (state_reg == sssp_pkg::S_TRACE)
            stack_reg[depth_reg[VB-1:0]] <= u_reg;
        if (state_reg == sssp_pkg::S_ONE && out_free)
        begin
            olast_reg <= 1'b1;
            odist_reg <= '0;
            if (present_reg[src_reg] && present_reg[dst_reg])
            begin
                ost_reg  <= sssp_pkg::ST_UNREACH;
                ovtx_reg <= dst_reg;
            end
            else
            begin
                ost_reg  <= sssp_pkg::ST_ABSENT;
                ovtx_reg <= '0;
            end
        end
        if (state_reg == sssp_pkg::S_EMIT && out_free)
        begin
            ost_reg   <= sssp_pkg::ST_FOUND;
            odist_reg <= (dst_reg == src_reg) ? '0
                         : sssp_pkg::DIST_BITS'(dist_reg[dst_reg]);
            ovtx_reg  <= stack_reg[VB'(depth_reg - 1'b1)];
            olast_reg <= (depth_reg == CB'(1));
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sssp_pkg::S_IDLE) |-> !s_tready)
        else $error("input accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed while stalled");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_no_write_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sssp_pkg::S_RELAX) |-> !mem_we)
        else $error("matrix written during query");

endmodule
